>>> hdl/csvbt_pkg.sv
package csvbt_pkg;

  localparam int MaxColumnsDefault = 255;

  localparam logic [7:0] CHAR_COMMA   = 8'h2c;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0a;
  localparam logic [7:0] CHAR_QUOTE   = 8'h22;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_TAB     = 8'h09;
  localparam logic [7:0] CHAR_CR      = 8'h0d;

  typedef enum logic [1:0] {
    KIND_BYTE      = 2'd0,
    KIND_FIELD_END = 2'd1,
    KIND_ROW_END   = 2'd2,
    KIND_ERROR     = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NEWLINE_IN_QUOTES = 2'd0,
    ERR_END_IN_QUOTES     = 2'd1,
    ERR_AFTER_QUOTE       = 2'd2
  } err_code_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data_byte;
    logic       field_quoted;
    err_code_t  error_code;
    logic [7:0] column_count;
    logic       column_mismatch;
  } result_t;

  function automatic logic is_blank(input logic [7:0] b);
    return (b == CHAR_SPACE) || (b == CHAR_TAB) || (b == CHAR_CR);
  endfunction

endpackage

>>> hdl/csv_byte_tokenizer_core.sv
// channel | direction | handshake            | beat
// in      | input     | in_valid / in_stall  | byte_value, end_of_input
// out     | output    | out_valid / out_stall| kind, data_byte, field_quoted, error_code,
//         |           |                      | column_count, column_mismatch
// cfg     | input     | cfg_valid / cfg_ready| cfg_data (check_columns)
//
// one input beat per cycle while in_stall is low; its result (if any) is registered as it is accepted.
// the parser state update is one small combinational step between the input ports and result regs.
// a result register plus a skid register decouple the sides; in_stall is high only while
// the skid register holds a beat, and it comes from a flop.
// rst is synchronous, active high; it clears parser state, check_columns and both valids.
module csv_byte_tokenizer_core
  import csvbt_pkg::*;
#(
  parameter int MAX_COLUMNS = MaxColumnsDefault
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] byte_value,
  input  logic       end_of_input,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] kind,
  output logic [7:0] data_byte,
  output logic       field_quoted,
  output logic [1:0] error_code,
  output logic [7:0] column_count,
  output logic       column_mismatch,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data
);

  localparam int CountCapInt = (MAX_COLUMNS < 255) ? MAX_COLUMNS : 255;
  localparam logic [7:0] COUNT_CAP = 8'(CountCapInt);

  typedef enum logic [2:0] {
    MODE_START,
    MODE_UNQUOTED,
    MODE_QUOTED,
    MODE_QUOTE_SEEN,
    MODE_AFTER_QUOTE,
    MODE_ERR_NEWLINE,
    MODE_ERR_END,
    MODE_ERR_AFTER
  } mode_t;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_BYTE,
    ACT_FIELD,
    ACT_ROW,
    ACT_ROW_ONLY,
    ACT_ERROR
  } act_t;

  mode_t      mode, mode_next;
  logic       check_columns;
  logic       row_has_fields, row_has_fields_next;
  logic [7:0] fields_in_row, fields_in_row_next;
  logic [7:0] first_row_fields, first_row_fields_next;
  logic       first_row_known, first_row_known_next;
  logic       quoted_flag, quoted_flag_next;

  result_t    out_reg, skid_reg, res;
  logic       skid_valid;
  logic       res_valid;

  act_t       act;
  err_code_t  err;
  logic       byte_quoted;
  logic [7:0] cnt_inc, row_cnt;
  logic       in_fire, out_take;

  assign in_fire  = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;
  assign in_stall = skid_valid;
  assign cfg_ready = 1'b1;

  assign cnt_inc = (fields_in_row < COUNT_CAP) ? fields_in_row + 8'd1 : fields_in_row;
  assign row_cnt = (act == ACT_ROW) ? cnt_inc : fields_in_row;

  always_comb begin
    act                   = ACT_NONE;
    err                   = ERR_NEWLINE_IN_QUOTES;
    byte_quoted           = 1'b0;
    mode_next             = mode;
    quoted_flag_next      = quoted_flag;
    row_has_fields_next   = row_has_fields;
    fields_in_row_next    = fields_in_row;
    first_row_fields_next = first_row_fields;
    first_row_known_next  = first_row_known;
    res                   = '0;
    res_valid             = 1'b0;

    unique case (mode)
      MODE_START: begin
        if (end_of_input) begin
          if (row_has_fields) act = ACT_ROW_ONLY;
        end else if (is_blank(byte_value)) begin
          act = ACT_NONE;
        end else if (byte_value == CHAR_QUOTE) begin
          quoted_flag_next = 1'b1;
          mode_next        = MODE_QUOTED;
        end else if (byte_value == CHAR_COMMA) begin
          act = ACT_FIELD;
        end else if (byte_value == CHAR_NEWLINE) begin
          act = ACT_ROW;
        end else begin
          act              = ACT_BYTE;
          quoted_flag_next = 1'b0;
          mode_next        = MODE_UNQUOTED;
        end
      end
      MODE_UNQUOTED: begin
        if (end_of_input || byte_value == CHAR_NEWLINE) act = ACT_ROW;
        else if (byte_value == CHAR_COMMA) act = ACT_FIELD;
        else act = ACT_BYTE;
      end
      MODE_QUOTED: begin
        if (end_of_input) begin
          act = ACT_ERROR;
          err = ERR_END_IN_QUOTES;
        end else if (byte_value == CHAR_NEWLINE) begin
          act = ACT_ERROR;
          err = ERR_NEWLINE_IN_QUOTES;
        end else if (byte_value == CHAR_QUOTE) begin
          mode_next = MODE_QUOTE_SEEN;
        end else begin
          act         = ACT_BYTE;
          byte_quoted = 1'b1;
        end
      end
      MODE_QUOTE_SEEN, MODE_AFTER_QUOTE: begin
        if (mode == MODE_QUOTE_SEEN && !end_of_input && byte_value == CHAR_QUOTE) begin
          // doubled quote inside a quoted field
          act         = ACT_BYTE;
          byte_quoted = 1'b1;
          mode_next   = MODE_QUOTED;
        end else begin
          mode_next = MODE_AFTER_QUOTE;
          if (end_of_input) act = ACT_ROW;
          else if (is_blank(byte_value)) act = ACT_NONE;
          else if (byte_value == CHAR_COMMA) act = ACT_FIELD;
          else if (byte_value == CHAR_NEWLINE) act = ACT_ROW;
          else begin
            act = ACT_ERROR;
            err = ERR_AFTER_QUOTE;
          end
        end
      end
      MODE_ERR_NEWLINE: begin
        act = ACT_ERROR;
        err = ERR_NEWLINE_IN_QUOTES;
      end
      MODE_ERR_END: begin
        act = ACT_ERROR;
        err = ERR_END_IN_QUOTES;
      end
      MODE_ERR_AFTER: begin
        act = ACT_ERROR;
        err = ERR_AFTER_QUOTE;
      end
      default: begin
        act = ACT_ERROR;
        err = ERR_AFTER_QUOTE;
      end
    endcase

    unique case (act)
      ACT_NONE: begin
        res_valid = 1'b0;
      end
      ACT_BYTE: begin
        res_valid          = 1'b1;
        res.kind           = KIND_BYTE;
        res.data_byte      = byte_value;
        res.field_quoted   = byte_quoted;
      end
      ACT_FIELD: begin
        res_valid           = 1'b1;
        res.kind            = KIND_FIELD_END;
        res.field_quoted    = quoted_flag;
        res.column_count    = cnt_inc;
        fields_in_row_next  = cnt_inc;
        row_has_fields_next = 1'b1;
        quoted_flag_next    = 1'b0;
        mode_next           = MODE_START;
      end
      ACT_ROW, ACT_ROW_ONLY: begin
        res_valid        = 1'b1;
        res.kind         = KIND_ROW_END;
        res.field_quoted = (act == ACT_ROW) ? quoted_flag : 1'b0;
        res.column_count = row_cnt;
        if (first_row_known) begin
          res.column_mismatch = check_columns && (row_cnt != first_row_fields);
        end else begin
          // the first row end records the reference count
          first_row_fields_next = row_cnt;
          first_row_known_next  = 1'b1;
        end
        fields_in_row_next  = '0;
        row_has_fields_next = 1'b0;
        quoted_flag_next    = 1'b0;
        mode_next           = MODE_START;
      end
      ACT_ERROR: begin
        res_valid      = 1'b1;
        res.kind       = KIND_ERROR;
        res.error_code = err;
        unique case (err)
          ERR_NEWLINE_IN_QUOTES: mode_next = MODE_ERR_NEWLINE;
          ERR_END_IN_QUOTES:     mode_next = MODE_ERR_END;
          default:               mode_next = MODE_ERR_AFTER;
        endcase
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode             <= MODE_START;
      check_columns    <= 1'b0;
      row_has_fields   <= 1'b0;
      fields_in_row    <= '0;
      first_row_fields <= '0;
      first_row_known  <= 1'b0;
      quoted_flag      <= 1'b0;
      out_valid        <= 1'b0;
      skid_valid       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) check_columns <= cfg_data;
      if (in_fire) begin
        mode             <= mode_next;
        row_has_fields   <= row_has_fields_next;
        fields_in_row    <= fields_in_row_next;
        first_row_fields <= first_row_fields_next;
        first_row_known  <= first_row_known_next;
        quoted_flag      <= quoted_flag_next;
      end
      if (skid_valid) begin
        if (out_take) begin
          out_reg    <= skid_reg;
          skid_valid <= 1'b0;
        end
      end else if (in_fire && res_valid) begin
        if (!out_valid || out_take) begin
          out_reg   <= res;
          out_valid <= 1'b1;
        end else begin
          // output beat still waiting, park the new one
          skid_reg   <= res;
          skid_valid <= 1'b1;
        end
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign kind            = out_reg.kind;
  assign data_byte       = out_reg.data_byte;
  assign field_quoted    = out_reg.field_quoted;
  assign error_code      = out_reg.error_code;
  assign column_count    = out_reg.column_count;
  assign column_mismatch = out_reg.column_mismatch;

`ifndef ASSERT_OFF
  a_skid_implies_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid beat held without an output beat");

  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_ERR_NEWLINE || mode == MODE_ERR_END || mode == MODE_ERR_AFTER)
      |=> $stable(mode))
    else $error("parser left an error mode");

  a_count_capped: assert property (@(posedge clk) disable iff (rst)
    (fields_in_row <= COUNT_CAP) && (first_row_fields <= COUNT_CAP))
    else $error("field count above cap");
`endif

endmodule
